@@ rtl/core/triggered_window_average_capture_core_defines.svh @@
// ---------------------------------------------------------------------------
// triggered window average capture: assertion macros
// concurrent assertion wrappers sampled on i_clk
// ---------------------------------------------------------------------------
`ifndef TRIGGERED_WINDOW_AVERAGE_CAPTURE_CORE_DEFINES_SVH
`define TRIGGERED_WINDOW_AVERAGE_CAPTURE_CORE_DEFINES_SVH

// checked outside reset only
`define TWAC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge
`define TWAC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/core/twac_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// twac_pkg
// shared types and constants of the triggered window average capture core
// ---------------------------------------------------------------------------
package twac_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 27;
    localparam int SIZE_W   = 11;
    localparam int WAIT_W   = 16;
    localparam int SLOT_W   = 13;
    localparam int OSLOT_W  = 12;
    localparam int CIDX_W   = 3;
    localparam int CNT_W    = 5;

    localparam logic [CIDX_W-1:0] REG_TRIG_RISING = 3'd0;
    localparam logic [CIDX_W-1:0] REG_TRIG_LEVEL  = 3'd1;
    localparam logic [CIDX_W-1:0] REG_TRIG_TMO    = 3'd2;
    localparam logic [CIDX_W-1:0] REG_WIN_SIZE    = 3'd3;
    localparam logic [CIDX_W-1:0] REG_CAP_LEN     = 3'd4;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_WAIT,
        PH_RECORD,
        PH_DONE
    } t_phase;

    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } t_fsm;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

@@ rtl/core/twac_div.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// twac_div
// bit-serial restoring divider, signed window sum over window size,
// truncated toward zero and saturated to the sample range
// ---------------------------------------------------------------------------
module twac_div import twac_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [SUM_W-1:0]    i_dividend,
    input  logic        [SIZE_W-1:0]   i_divisor,
    output t_div_stat                  o_stat,
    output logic signed [SAMPLE_W-1:0] o_quotient
);

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(SUM_W - 1);
    localparam logic [SUM_W-1:0] MAG_POS   = SUM_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic [SUM_W-1:0] MAG_NEG   = SUM_W'(1 << (SAMPLE_W - 1));

    logic              r_busy, n_busy;
    logic              r_have, n_have;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_neg, n_neg;
    logic [SUM_W-1:0]  r_mag, n_mag;
    logic [SIZE_W-1:0] r_rem, n_rem;
    logic [SIZE_W-1:0] r_div, n_div;

    logic [SIZE_W:0]   w_trial;
    logic [SIZE_W:0]   w_diff;
    logic              w_ge;

    assign w_trial = {r_rem, r_mag[SUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_have = r_have;
        n_cnt  = r_cnt;
        n_neg  = r_neg;
        n_mag  = r_mag;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_have = 1'b0;
            n_cnt  = '0;
            n_neg  = i_dividend[SUM_W-1];
            n_mag  = i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[SIZE_W-1:0] : w_trial[SIZE_W-1:0];
            n_mag = {r_mag[SUM_W-2:0], w_ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST_STEP) begin
                n_busy = 1'b0;
                n_have = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_have <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_have <= n_have;
            r_cnt  <= n_cnt;
        end
        r_neg <= n_neg;
        r_mag <= n_mag;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    always_comb begin
        if (r_neg) begin
            if (r_mag > MAG_NEG) begin
                o_quotient = {1'b1, {(SAMPLE_W-1){1'b0}}};
            end else begin
                o_quotient = -$signed(r_mag[SAMPLE_W-1:0]);
            end
        end else begin
            if (r_mag > MAG_POS) begin
                o_quotient = {1'b0, {(SAMPLE_W-1){1'b1}}};
            end else begin
                o_quotient = $signed(r_mag[SAMPLE_W-1:0]);
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_have;

endmodule

@@ rtl/core/triggered_window_average_capture_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// triggered_window_average_capture_core
// edge triggered boxcar averaging capture of signed 16-bit samples
// ---------------------------------------------------------------------------
// After a rearm word (command 1) the first sample is only remembered; the core
// then waits for a rising or falling crossing of trigger_level, or for
// trigger_timeout checked samples, and from that sample on sums windows of
// window_size samples. Each full window yields one word: the sum divided by the
// window size (truncated toward zero, saturated), its slot and a capture_done
// flag on the last of capture_length words, after which samples are ignored
// until the next rearm. A word that does not close a window is taken without
// a stall. A word that closes a window holds the input stalled while the
// divider runs its one-bit-per-cycle steps and then while the quotient is
// loaded into the output register; the stall lasts longer while the output
// register still holds a word that has not been taken. A finished average
// waits in the output register while the next samples are taken. Configuration
// registers may be written whenever the core is idle; the write port never
// stalls.
// ---------------------------------------------------------------------------
module triggered_window_average_capture_core import twac_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,

    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_command,
    input  logic signed [SAMPLE_W-1:0] i_sample,

    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_average,
    output logic        [OSLOT_W-1:0]  o_slot,
    output logic                       o_capture_done,

    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic        [CIDX_W-1:0]   i_cfg_index,
    input  logic        [SAMPLE_W-1:0] i_cfg_data
);

    // configuration
    logic                       r_trig_rising;
    logic signed [SAMPLE_W-1:0] r_trig_level;
    logic        [WAIT_W-1:0]   r_trig_tmo;
    logic        [SIZE_W-1:0]   r_win_size;
    logic        [SLOT_W-1:0]   r_cap_len;

    // capture state
    t_phase                     r_phase, n_phase;
    logic signed [SAMPLE_W-1:0] r_prev, n_prev;
    logic        [WAIT_W-1:0]   r_wait, n_wait;
    logic        [SIZE_W-1:0]   r_wcount, n_wcount;
    logic signed [SUM_W-1:0]    r_wsum, n_wsum;
    logic        [SLOT_W-1:0]   r_slot_idx, n_slot_idx;

    // pending result fields
    logic        [OSLOT_W-1:0]  r_pend_slot, n_pend_slot;
    logic                       r_pend_done, n_pend_done;

    // control
    t_fsm                       r_state, n_state;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_average;
    logic        [OSLOT_W-1:0]  r_slot;
    logic                       r_capture_done;

    logic                       w_accept;
    logic                       w_start;
    logic                       w_load;
    logic                       w_out_free;
    logic signed [SUM_W-1:0]    w_dividend;
    logic        [SIZE_W-1:0]   w_size;
    logic        [WAIT_W-1:0]   w_tmo;
    logic        [SLOT_W-1:0]   w_len;
    t_div_stat                  w_div_stat;
    logic signed [SAMPLE_W-1:0] w_quotient;

    logic                       w_hit;
    logic                       w_rec;
    logic        [SIZE_W-1:0]   w_wc_next;
    logic signed [SUM_W-1:0]    w_sum_base;
    logic        [SLOT_W-1:0]   w_slot_next;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_rising <= 1'b1;
            r_trig_level  <= '0;
            r_trig_tmo    <= WAIT_W'(4410);
            r_win_size    <= SIZE_W'(1);
            r_cap_len     <= SLOT_W'(128);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_TRIG_RISING: r_trig_rising <= i_cfg_data[0];
                REG_TRIG_LEVEL:  r_trig_level  <= $signed(i_cfg_data);
                REG_TRIG_TMO:    r_trig_tmo    <= i_cfg_data;
                REG_WIN_SIZE:    r_win_size    <= i_cfg_data[SIZE_W-1:0];
                REG_CAP_LEN:     r_cap_len     <= i_cfg_data[SLOT_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_size   = (r_win_size == '0) ? SIZE_W'(1) : r_win_size;
    assign w_tmo    = (r_trig_tmo == '0) ? WAIT_W'(1) : r_trig_tmo;
    assign w_len    = (r_cap_len == '0)  ? SLOT_W'(1) : r_cap_len;

    // sample handling
    always_comb begin
        n_phase     = r_phase;
        n_prev      = r_prev;
        n_wait      = r_wait;
        n_wcount    = r_wcount;
        n_wsum      = r_wsum;
        n_slot_idx  = r_slot_idx;
        n_pend_slot = r_pend_slot;
        n_pend_done = r_pend_done;
        w_start     = 1'b0;
        w_hit       = 1'b0;
        w_rec       = 1'b0;
        w_wc_next   = r_wcount + 1'b1;
        w_sum_base  = (r_wcount == '0) ? '0 : r_wsum;
        w_dividend  = w_sum_base + SUM_W'(i_sample);
        w_slot_next = r_slot_idx + 1'b1;
        if (w_accept) begin
            if (i_command) begin
                n_phase    = PH_FIRST;
                n_prev     = '0;
                n_wait     = '0;
                n_wcount   = '0;
                n_wsum     = '0;
                n_slot_idx = '0;
            end else begin
                case (r_phase)
                    PH_FIRST: begin
                        n_prev  = i_sample;
                        n_wait  = '0;
                        n_phase = PH_WAIT;
                    end
                    PH_WAIT: begin
                        if (r_trig_rising) begin
                            w_hit = (r_prev <= r_trig_level) && (i_sample >= r_trig_level);
                        end else begin
                            w_hit = (r_prev >= r_trig_level) && (i_sample <= r_trig_level);
                        end
                        n_prev = i_sample;
                        n_wait = r_wait + 1'b1;
                        if (n_wait >= w_tmo) begin
                            w_hit = 1'b1;
                        end
                        if (w_hit) begin
                            n_phase = PH_RECORD;
                            w_rec   = 1'b1;
                        end
                    end
                    PH_RECORD: w_rec = 1'b1;
                    default: ;
                endcase
                if (w_rec) begin
                    n_wsum = w_dividend;
                    if ((w_wc_next >= w_size) || (w_wc_next == '0)) begin
                        w_start     = 1'b1;
                        n_wcount    = '0;
                        n_pend_slot = r_slot_idx[OSLOT_W-1:0];
                        n_slot_idx  = w_slot_next;
                        n_pend_done = (w_slot_next >= w_len) || (w_slot_next == '0);
                        if (n_pend_done) begin
                            n_phase = PH_DONE;
                        end
                    end else begin
                        n_wcount = w_wc_next;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_FIRST;
            r_prev     <= '0;
            r_wait     <= '0;
            r_wcount   <= '0;
            r_wsum     <= '0;
            r_slot_idx <= '0;
        end else begin
            r_phase    <= n_phase;
            r_prev     <= n_prev;
            r_wait     <= n_wait;
            r_wcount   <= n_wcount;
            r_wsum     <= n_wsum;
            r_slot_idx <= n_slot_idx;
        end
        r_pend_slot <= n_pend_slot;
        r_pend_done <= n_pend_done;
    end

    twac_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_size),
        .o_stat     (w_div_stat),
        .o_quotient (w_quotient)
    );

    assign w_out_free = !r_out_valid || !i_out_stall;

    // control next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_start) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_stall = 1'b1;
        w_load     = 1'b0;
        case (r_state)
            ST_IDLE: o_in_stall = 1'b0;
            ST_DIV:  w_load = !w_div_stat.busy && w_div_stat.done && w_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_load) begin
            r_average      <= w_quotient;
            r_slot         <= r_pend_slot;
            r_capture_done <= r_pend_done;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_average      = r_average;
    assign o_slot         = r_slot;
    assign o_capture_done = r_capture_done;

endmodule

@@ rtl/core/twac_chk.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// twac_chk
// port level checks of the triggered window average capture core
// ---------------------------------------------------------------------------
`include "triggered_window_average_capture_core_defines.svh"

module twac_chk import twac_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       o_in_stall,
    input  logic                       i_command,
    input  logic                       o_out_valid,
    input  logic                       i_out_stall,
    input  logic signed [SAMPLE_W-1:0] o_average,
    input  logic        [OSLOT_W-1:0]  o_slot,
    input  logic                       o_capture_done,
    input  logic                       o_cfg_ready
);

    // a stalled result word holds
    `TWAC_ASSERT(a_out_hold,
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_average) &&
        $stable(o_slot) && $stable(o_capture_done),
        "stalled result word changed")

    // a rearm never starts a division
    `TWAC_ASSERT(a_rearm_no_stall,
        i_in_valid && !o_in_stall && i_command |=> !o_in_stall,
        "input stalled after rearm")

    // a new result only comes out of the divider, which stalls the input
    `TWAC_ASSERT(a_out_after_div, $rose(o_out_valid) |-> $past(o_in_stall), "result without division")

    // register writes are never held off
    `TWAC_ASSERT_ALWAYS(a_cfg_ready, i_rst_n |-> o_cfg_ready, "configuration port not ready")

endmodule

bind triggered_window_average_capture_core twac_chk u_twac_chk (.*);
